>>> rtl/core/bsse_pkg.sv
// Package for the bitmap set stack evaluator core.
// Holds request and status codes, the word width and the range mask function.
// No dependencies.
`default_nettype none

package bsse_pkg;

	localparam int WORD_W      = 64;
	localparam int WIDX_MAX_W  = 14;
	localparam int ID_FIELD_MAX = 4095;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic [2:0] REQ_PUSH      = 3'd0;
	localparam logic [2:0] REQ_ADD       = 3'd1;
	localparam logic [2:0] REQ_UNION     = 3'd2;
	localparam logic [2:0] REQ_INTERSECT = 3'd3;
	localparam logic [2:0] REQ_DIFF      = 3'd4;
	localparam logic [2:0] REQ_INVERT    = 3'd5;
	localparam logic [2:0] REQ_READ      = 3'd6;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_UNDER    = 2'd1;
	localparam logic [1:0] STS_OVER     = 2'd2;
	localparam logic [1:0] STS_ID_RANGE = 2'd3;

	// bits of word w that lie in 1..m
	function automatic word_t range_mask(input logic [11:0] m, input logic [WIDX_MAX_W-1:0] w);
		logic [WIDX_MAX_W-1:0] hw;
		word_t mk;
		hw = WIDX_MAX_W'(m[11:6]);
		if (w > hw) begin
			mk = '0;
		end else if (w < hw) begin
			mk = '1;
		end else begin
			mk = word_t'('1) >> (6'd63 - m[5:0]);
		end
		if (w == '0) begin
			mk[0] = 1'b0;
		end
		return mk;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bitmap_set_stack_evaluator_core.sv
// Top level of the bitmap set stack evaluator core.
// Depends on bsse_pkg and bsse_store.
//
// Usage:
//   s_axis carries one request: tuser = req_type, tdata = member_id, word_index.
//   m_axis returns one result per request: tuser = status,
//   tdata = read_data, stack_level.
//   cfg_valid/cfg_data write max_id; write only while no request is in flight.
// Request handling (W = ID_SPACE/64 words per set):
//   push           clear sweep of the W words of the new set
//   union/and/diff sweep with two reads per word on the single read port
//   invert         sweep that reads and writes back every word of the top set
//   add id         read-modify-write of one word
//   read word      read of one word; errors and no-ops go straight to the result
//   One request is processed at a time; the next is taken once the result
//   sits in the output register.
// Reset clears the stack count, returns max_id to 4095 and empties the output
// register; the set memory needs no clearing since a push clears its set.
// A stalled receiver holds the result in the output register; one further
// request may be accepted and finishes up to the point of delivery.
`default_nettype none

module bitmap_set_stack_evaluator_core #(
	parameter int STACK_DEPTH = 8,
	parameter int ID_SPACE    = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,  // member_id[11:0], word_index[17:12], zero pad
	input  wire  [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [71:0] m_axis_tdata,  // read_data[63:0], stack_level[67:64], zero pad
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [11:0] cfg_data       // max_id
);
	import bsse_pkg::*;

	localparam int SET_WORDS = ID_SPACE / 64;
	localparam int WW        = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;
	localparam int SB        = $clog2(STACK_DEPTH);
	localparam int CW        = $clog2(STACK_DEPTH + 1);
	localparam int DEPTH     = STACK_DEPTH * SET_WORDS;
	localparam int AW        = $clog2(DEPTH);
	localparam int CAP       = (ID_SPACE - 1 < ID_FIELD_MAX) ? ID_SPACE - 1 : ID_FIELD_MAX;
	localparam logic [11:0]   CAP_ID    = 12'(CAP);
	localparam logic [WW-1:0] LAST_WORD = WW'(SET_WORDS - 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_EXEC    = 3'd1;
	localparam logic [2:0] ST_CLEAR   = 3'd2;
	localparam logic [2:0] ST_SWEEP   = 3'd3;
	localparam logic [2:0] ST_ADD_WR  = 3'd4;
	localparam logic [2:0] ST_RD_WAIT = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	function automatic logic [AW-1:0] mem_addr(input logic [SB-1:0] s, input logic [WW-1:0] w);
		return AW'(AW'(s) * AW'(SET_WORDS) + AW'(w));
	endfunction

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [11:0]   max_id_q;
	logic [2:0]    req_q;
	logic [11:0]   id_q;
	logic [5:0]    widx_q;
	logic [1:0]    status_q;
	word_t         data_q;
	logic          binary_q;
	logic          issue_q;
	logic          phase_q;
	logic [WW-1:0] word_q;
	logic          valid_s1;
	logic          phase_s1;
	logic          last_s1;
	logic [WW-1:0] word_s1;
	word_t         a_word_q;
	logic          m_valid_q;
	logic [1:0]    m_status_q;
	word_t         m_data_q;
	logic [3:0]    m_level_q;

	logic [11:0]   eff_max;
	logic [SB-1:0] top_slot;
	logic [SB-1:0] sec_slot;
	logic [SB-1:0] push_slot;
	logic [WW-1:0] id_word;
	logic [WW-1:0] rd_word;
	logic          widx_ok;
	logic          id_bad;
	word_t         mask_s1;
	word_t         b_masked;
	word_t         sweep_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	word_t         wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	word_t         rd_data;
	logic          out_free;

	assign eff_max   = (max_id_q > CAP_ID) ? CAP_ID : max_id_q;
	assign top_slot  = SB'(count_q - 1'b1);
	assign sec_slot  = SB'(count_q - 2'd2);
	assign push_slot = SB'(count_q);
	assign id_word   = WW'(id_q[11:6]);
	assign rd_word   = WW'(widx_q);
	assign widx_ok   = 32'(widx_q) < SET_WORDS;
	assign id_bad    = id_q > eff_max;
	assign out_free  = !m_valid_q || m_axis_tready;

	assign mask_s1  = range_mask(eff_max, WIDX_MAX_W'(word_s1));
	assign b_masked = rd_data & mask_s1;

	always_comb begin
		case (req_q)
			REQ_UNION:     sweep_data = a_word_q | b_masked;
			REQ_INTERSECT: sweep_data = (a_word_q & ~mask_s1) | (a_word_q & b_masked);
			REQ_DIFF:      sweep_data = a_word_q & ~b_masked;
			default:       sweep_data = rd_data ^ mask_s1;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mem_addr(top_slot, word_q);
		wr_en   = 1'b0;
		wr_addr = mem_addr(top_slot, word_s1);
		wr_data = sweep_data;
		case (state_q)
			ST_EXEC: begin
				if (count_q != '0) begin
					if (req_q == REQ_ADD && !id_bad && id_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = mem_addr(top_slot, id_word);
					end else if (req_q == REQ_READ && widx_ok) begin
						rd_en   = 1'b1;
						rd_addr = mem_addr(top_slot, rd_word);
					end
				end
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = mem_addr(push_slot, word_q);
				wr_data = '0;
			end
			ST_ADD_WR: begin
				wr_en   = 1'b1;
				wr_addr = mem_addr(top_slot, id_word);
				wr_data = rd_data | (word_t'(1) << id_q[5:0]);
			end
			ST_SWEEP: begin
				rd_en   = issue_q;
				rd_addr = mem_addr((binary_q && !phase_q) ? sec_slot : top_slot, word_q);
				wr_en   = valid_s1 && (!binary_q || phase_s1);
				wr_addr = mem_addr(binary_q ? sec_slot : top_slot, word_s1);
			end
			default: begin
			end
		endcase
	end

	bsse_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_id_q <= 12'(ID_FIELD_MAX);
		end else if (cfg_valid) begin
			max_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q  <= s_axis_tuser;
			id_q   <= s_axis_tdata[11:0];
			widx_q <= s_axis_tdata[17:12];
		end
		phase_s1 <= phase_q;
		word_s1  <= word_q;
		last_s1  <= (word_q == LAST_WORD) && (!binary_q || phase_q);
		if (valid_s1 && binary_q && !phase_s1) begin
			a_word_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			status_q <= STS_OK;
			data_q   <= '0;
			binary_q <= 1'b0;
			issue_q  <= 1'b0;
			phase_q  <= 1'b0;
			word_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SWEEP) && issue_q;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					data_q   <= '0;
					word_q   <= '0;
					phase_q  <= 1'b0;
					binary_q <= (req_q == REQ_UNION) || (req_q == REQ_INTERSECT)
						|| (req_q == REQ_DIFF);
					case (req_q)
						REQ_PUSH: begin
							if (count_q == CW'(STACK_DEPTH)) begin
								status_q <= STS_OVER;
								state_q  <= ST_DONE;
							end else begin
								status_q <= STS_OK;
								state_q  <= ST_CLEAR;
							end
						end
						REQ_ADD: begin
							if (count_q == '0) begin
								status_q <= STS_UNDER;
								state_q  <= ST_DONE;
							end else if (id_bad) begin
								status_q <= STS_ID_RANGE;
								state_q  <= ST_DONE;
							end else if (id_q != '0) begin
								status_q <= STS_OK;
								state_q  <= ST_ADD_WR;
							end else begin
								status_q <= STS_OK;
								state_q  <= ST_DONE;
							end
						end
						REQ_READ: begin
							if (count_q == '0) begin
								status_q <= STS_UNDER;
								state_q  <= ST_DONE;
							end else if (widx_ok) begin
								status_q <= STS_OK;
								state_q  <= ST_RD_WAIT;
							end else begin
								status_q <= STS_OK;
								state_q  <= ST_DONE;
							end
						end
						REQ_INVERT: begin
							if (count_q == '0) begin
								status_q <= STS_UNDER;
								state_q  <= ST_DONE;
							end else begin
								status_q <= STS_OK;
								issue_q  <= 1'b1;
								state_q  <= ST_SWEEP;
							end
						end
						REQ_UNION, REQ_INTERSECT, REQ_DIFF: begin
							if (count_q < CW'(2)) begin
								status_q <= STS_UNDER;
								state_q  <= ST_DONE;
							end else begin
								status_q <= STS_OK;
								issue_q  <= 1'b1;
								state_q  <= ST_SWEEP;
							end
						end
						default: begin
							status_q <= STS_OK;
							state_q  <= ST_DONE;
						end
					endcase
				end
				ST_CLEAR: begin
					if (word_q == LAST_WORD) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						word_q <= word_q + 1'b1;
					end
				end
				ST_ADD_WR: begin
					state_q <= ST_DONE;
				end
				ST_RD_WAIT: begin
					data_q  <= rd_data;
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (issue_q) begin
						if (binary_q && !phase_q) begin
							phase_q <= 1'b1;
						end else begin
							phase_q <= 1'b0;
							if (word_q == LAST_WORD) begin
								issue_q <= 1'b0;
							end else begin
								word_q <= word_q + 1'b1;
							end
						end
					end
					if (valid_s1 && last_s1) begin
						if (binary_q) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_status_q <= status_q;
			m_data_q   <= data_q;
			m_level_q  <= 4'(count_q);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {4'd0, m_level_q, m_data_q};

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same set word in one cycle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == CW'($past(count_q) + 1'b1)) || (count_q == CW'($past(count_q) - 1'b1))))
		else $error("stack count moved by more than one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (count_q < CW'(STACK_DEPTH)))
		else $error("push clear sweep on a full stack");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == ST_CLEAR) || (state_q == ST_SWEEP) || (state_q == ST_ADD_WR)))
		else $error("memory write outside a modify state");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bsse_store.sv
// Set store memory: one write port, one read port, registered read data.
// Depends on bsse_pkg for the word type.
`default_nettype none

module bsse_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire  [AW-1:0]              wr_addr,
	input  wire  bsse_pkg::word_t      wr_data,
	input  wire                        rd_en,
	input  wire  [AW-1:0]              rd_addr,
	output bsse_pkg::word_t            rd_data
);
	import bsse_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
